FILE: rtl/core/lse_pkg.sv
// ============================================================================
// lse_pkg
// Shared types, constants and helpers for the LSB embed/extract core.
// ============================================================================
package lse_pkg;

    localparam int BYTE_W       = 8;
    localparam int OFFSET_W     = 24;
    localparam int STRIDE_W     = 16;
    localparam int LENGTH_W     = 24;
    localparam int COUNTDOWN_W  = 25;
    localparam int BITPOS_W     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam logic [BYTE_W-1:0]   MASK_ONE   = 8'h01;
    localparam logic [BYTE_W-1:0]   MASK_FOUR  = 8'h0F;
    localparam logic [BITPOS_W-1:0] BITPOS_TOP = 3'd7;

    localparam logic                DIR_EMBED   = 1'b0;
    localparam logic                DIR_EXTRACT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SLOT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LENGTH = 3'd4;

    typedef struct packed {
        logic                direction;
        logic                bits_per_slot_mode;
        logic [OFFSET_W-1:0] start_offset;
        logic [STRIDE_W-1:0] stride;
        logic [LENGTH_W-1:0] message_length;
    } t_cfg;

    // Restart request toward the slot tracker, with the countdown to load.
    typedef struct packed {
        logic                   restart;
        logic [COUNTDOWN_W-1:0] restart_dist;
    } t_cfg_ctl;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              message_taken;
        logic [BYTE_W-1:0] recovered_byte;
        logic              recovered_valid;
    } t_result;

    // A zero stride behaves as a stride of one.
    function automatic logic [STRIDE_W-1:0] eff_stride(input logic [STRIDE_W-1:0] stride);
        eff_stride = (stride == '0) ? STRIDE_W'(1) : stride;
    endfunction

    function automatic logic [COUNTDOWN_W-1:0] first_slot_distance(input t_cfg cfg);
        first_slot_distance = COUNTDOWN_W'(cfg.start_offset)
                            + COUNTDOWN_W'(eff_stride(cfg.stride))
                            - COUNTDOWN_W'(1);
    endfunction

endpackage

FILE: rtl/core/lse_if.sv
// ============================================================================
// lse_if
// Valid/ready channel interfaces for carrier input, result output and
// configuration writes.
// ============================================================================
interface lse_in_if;
    import lse_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] carrier_byte;
    logic [BYTE_W-1:0] message_byte;
    logic              last_byte;

    modport source (output valid, carrier_byte, message_byte, last_byte, input ready);
    modport sink   (input valid, carrier_byte, message_byte, last_byte, output ready);
endinterface

interface lse_out_if;
    import lse_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              message_taken;
    logic [BYTE_W-1:0] recovered_byte;
    logic              recovered_valid;

    modport source (output valid, out_byte, message_taken, recovered_byte, recovered_valid,
                    input ready);
    modport sink   (input valid, out_byte, message_taken, recovered_byte, recovered_valid,
                    output ready);
endinterface

interface lse_cfg_if;
    import lse_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/lsb_stego_embed_extract_core.sv
// ============================================================================
// lsb_stego_embed_extract_core
// LSB steganography embed/extract engine for a stream of carrier bytes.
// ============================================================================
// Usage:
// Carrier beats arrive on i_in (carrier byte, current message byte, last
// flag). Each beat yields exactly one result beat on o_out: the carrier
// byte, with its low bits replaced at active slots when embedding, plus the
// message_taken flag and, when extracting, a recovered byte with its valid.
// Present a new message byte on the beat after one that reports
// message_taken. Configuration is written through i_cfg (always ready)
// while the core is idle; every write to a defined register restarts the
// carrier walk, as does a beat with last_byte set.
// Results from the slot logic are registered in the output buffer, one beat
// per cycle while o_out.ready is high; a stalled result waits in the buffer.
// A two-entry output buffer lets one more beat enter while a result is
// stalled; i_in.ready drops only when both entries are full.
// Reset (synchronous, active low) restores the register defaults: embed,
// one bit per slot, zero offset, stride one, zero message length.
// ============================================================================
module lsb_stego_embed_extract_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lse_in_if.sink    i_in,
    lse_cfg_if.sink   i_cfg,
    lse_out_if.source o_out
);
    import lse_pkg::*;

    t_cfg     cfg;
    t_cfg_ctl ctl;
    t_result  result;
    t_result  out_data;
    logic     can_push;
    logic     in_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = can_push;
    assign in_accept   = i_in.valid && can_push;

    lse_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg),
        .o_ctl      (ctl)
    );

    lse_slot_ctrl u_slot_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_ctl          (ctl),
        .i_accept       (in_accept),
        .i_carrier_byte (i_in.carrier_byte),
        .i_message_byte (i_in.message_byte),
        .i_last_byte    (i_in.last_byte),
        .o_result       (result)
    );

    lse_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_accept),
        .i_data     (result),
        .o_can_push (can_push),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_data     (out_data)
    );

    assign o_out.out_byte        = out_data.out_byte;
    assign o_out.message_taken   = out_data.message_taken;
    assign o_out.recovered_byte  = out_data.recovered_byte;
    assign o_out.recovered_valid = out_data.recovered_valid;

endmodule

FILE: rtl/core/lse_cfg_regs.sv
// ============================================================================
// lse_cfg_regs
// Configuration register file. Every write to a defined register restarts
// the carrier walk using the newly written values.
// ============================================================================
module lse_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [lse_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [lse_pkg::CFG_DATA_W-1:0] i_wr_data,
    output lse_pkg::t_cfg                 o_cfg,
    output lse_pkg::t_cfg_ctl             o_ctl
);
    import lse_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic hit;

    always_comb begin
        n_cfg = r_cfg;
        hit   = 1'b0;
        if (i_wr_en) begin
            unique case (i_wr_index)
                REG_DIRECTION: begin
                    n_cfg.direction = i_wr_data[0];
                    hit = 1'b1;
                end
                REG_BITS_PER_SLOT: begin
                    n_cfg.bits_per_slot_mode = i_wr_data[0];
                    hit = 1'b1;
                end
                REG_START_OFFSET: begin
                    n_cfg.start_offset = i_wr_data[OFFSET_W-1:0];
                    hit = 1'b1;
                end
                REG_STRIDE: begin
                    n_cfg.stride = i_wr_data[STRIDE_W-1:0];
                    hit = 1'b1;
                end
                REG_MESSAGE_LENGTH: begin
                    n_cfg.message_length = i_wr_data[LENGTH_W-1:0];
                    hit = 1'b1;
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction          <= DIR_EMBED;
            r_cfg.bits_per_slot_mode <= 1'b0;
            r_cfg.start_offset       <= '0;
            r_cfg.stride             <= STRIDE_W'(1);
            r_cfg.message_length     <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg              = r_cfg;
    assign o_ctl.restart      = hit;
    assign o_ctl.restart_dist = first_slot_distance(n_cfg);

endmodule

FILE: rtl/core/lse_slot_ctrl.sv
// ============================================================================
// lse_slot_ctrl
// Slot countdown, bit position, message count and extraction assembly.
// Computes the result for one carrier beat and advances the state on accept.
// ============================================================================
module lse_slot_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lse_pkg::t_cfg              i_cfg,
    input  lse_pkg::t_cfg_ctl          i_ctl,
    input  logic                       i_accept,
    input  logic [lse_pkg::BYTE_W-1:0] i_carrier_byte,
    input  logic [lse_pkg::BYTE_W-1:0] i_message_byte,
    input  logic                       i_last_byte,
    output lse_pkg::t_result           o_result
);
    import lse_pkg::*;

    logic [COUNTDOWN_W-1:0] r_countdown, n_countdown;
    logic [BITPOS_W-1:0]    r_bitpos,    n_bitpos;
    logic [LENGTH_W-1:0]    r_msg_index, n_msg_index;
    logic [BYTE_W-1:0]      r_assembly,  n_assembly;

    logic                   at_slot;
    logic                   active;
    logic                   four;
    logic [BITPOS_W-1:0]    shift;
    logic                   done;
    logic [BYTE_W-1:0]      mask;
    logic [BYTE_W-1:0]      embedded;
    logic [BYTE_W-1:0]      assembled;

    always_comb begin
        at_slot   = (r_countdown == '0);
        active    = at_slot && (r_msg_index < i_cfg.message_length);
        four      = i_cfg.bits_per_slot_mode;
        // In four-bit mode only the high nibble (shift 4) and low nibble exist.
        shift     = four ? {r_bitpos[2], 2'b00} : r_bitpos;
        done      = (shift == '0);
        mask      = four ? MASK_FOUR : MASK_ONE;
        embedded  = (i_carrier_byte & ~mask) | ((i_message_byte >> shift) & mask);
        assembled = (r_assembly & ~(mask << shift)) | ((i_carrier_byte & mask) << shift);

        o_result.out_byte        = (active && i_cfg.direction == DIR_EMBED)
                                   ? embedded : i_carrier_byte;
        o_result.message_taken   = active && done && (i_cfg.direction == DIR_EMBED);
        o_result.recovered_valid = active && done && (i_cfg.direction == DIR_EXTRACT);
        o_result.recovered_byte  = o_result.recovered_valid ? assembled : '0;

        n_countdown = at_slot ? (COUNTDOWN_W'(eff_stride(i_cfg.stride)) - COUNTDOWN_W'(1))
                              : (r_countdown - COUNTDOWN_W'(1));
        n_bitpos    = r_bitpos;
        n_msg_index = r_msg_index;
        n_assembly  = r_assembly;
        if (active) begin
            if (done) begin
                n_bitpos    = BITPOS_TOP;
                n_msg_index = r_msg_index + LENGTH_W'(1);
            end else begin
                n_bitpos    = four ? '0 : (shift - BITPOS_W'(1));
            end
            if (i_cfg.direction == DIR_EXTRACT) begin
                n_assembly = done ? '0 : assembled;
            end
        end
        if (i_last_byte) begin
            n_countdown = first_slot_distance(i_cfg);
            n_bitpos    = BITPOS_TOP;
            n_msg_index = '0;
            n_assembly  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= '0;
            r_bitpos    <= BITPOS_TOP;
            r_msg_index <= '0;
            r_assembly  <= '0;
        end else if (i_ctl.restart) begin
            r_countdown <= i_ctl.restart_dist;
            r_bitpos    <= BITPOS_TOP;
            r_msg_index <= '0;
            r_assembly  <= '0;
        end else if (i_accept) begin
            r_countdown <= n_countdown;
            r_bitpos    <= n_bitpos;
            r_msg_index <= n_msg_index;
            r_assembly  <= n_assembly;
        end
    end

endmodule

FILE: rtl/core/lse_out_buf.sv
// ============================================================================
// lse_out_buf
// Two-entry output buffer: a result register plus a skid register, so the
// input side keeps taking beats while one result waits on the receiver.
// ============================================================================
module lse_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lse_pkg::t_result i_data,
    output logic             o_can_push,
    output logic             o_valid,
    input  logic             i_ready,
    output lse_pkg::t_result o_data
);
    import lse_pkg::*;

    logic    r_main_valid;
    t_result r_main_data;
    logic    r_skid_valid;
    t_result r_skid_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_main_valid) begin
            r_main_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_data     = r_main_data;

endmodule
